>>> src/pcmq_pkg.sv
package pcmq_pkg;

   // Port field widths.
   localparam int OP_W      = 3;
   localparam int ID_W      = 6;
   localparam int PAYLOAD_W = 32;
   localparam int PRIO_W    = 16;
   localparam int STATUS_W  = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
   localparam logic [OP_W-1:0] OP_PROMOTE = 3'd1;
   localparam logic [OP_W-1:0] OP_POP     = 3'd2;
   localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD_ID = 2'd3;

endpackage

>>> src/priority_collection_max_queue.sv
// Priority store with increase-key. Each entry (payload, priority, live mark) sits in one
// word of a single-port-read memory; ids are handed out in order by add and never reused.
// The receiver cannot stall: every transfer on the request side produces exactly one
// response strobe on rsp_valid, which must be taken in that cycle. Add, and any request
// that is refused at once (store full, unknown op, unassigned id, pop or peek before any
// id has been handed out), answers in the cycle after the transfer and keeps busy low.
// Promote and lookup of an assigned id take one memory read, then the answer (with the
// write-back for promote). Pop and peek scan every id handed out so far (at most DEPTH)
// through the one memory read port, one entry per cycle, and then answer, even when
// every entry has been removed. No clearing pass is needed after reset: the id counter
// bounds every read.
module priority_collection_max_queue #(
   parameter int DEPTH        = 64,
   parameter int PAYLOAD_BITS = 32,
   parameter int PRIO_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pcmq_pkg::OP_W-1:0]            req_op,
   input  logic [pcmq_pkg::ID_W-1:0]            req_id,
   input  logic [pcmq_pkg::PAYLOAD_W-1:0]       req_payload,
   output logic                                 rsp_valid,
   output logic [pcmq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [pcmq_pkg::ID_W-1:0]            rsp_result_id,
   output logic [pcmq_pkg::PAYLOAD_W-1:0]       rsp_result_payload,
   output logic [pcmq_pkg::PRIO_W-1:0]          rsp_result_priority,
   output logic                                 rsp_live
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = IDX_W + 1;

   typedef struct packed {
      logic                    live;
      logic [PRIO_BITS-1:0]    prio;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   typedef enum logic [1:0] {ST_IDLE, ST_ENTRY, ST_SCAN, ST_SCAN_DONE} state_type;

   // Width conversions between the port fields and the stored fields.
   function automatic logic [PAYLOAD_BITS-1:0] pay_to_store(
      input logic [pcmq_pkg::PAYLOAD_W-1:0] v);
      logic [PAYLOAD_BITS+pcmq_pkg::PAYLOAD_W-1:0] w;
      w = {{PAYLOAD_BITS{1'b0}}, v};
      return w[PAYLOAD_BITS-1:0];
   endfunction

   function automatic logic [pcmq_pkg::PAYLOAD_W-1:0] pay_to_port(
      input logic [PAYLOAD_BITS-1:0] v);
      logic [PAYLOAD_BITS+pcmq_pkg::PAYLOAD_W-1:0] w;
      w = {{pcmq_pkg::PAYLOAD_W{1'b0}}, v};
      return w[pcmq_pkg::PAYLOAD_W-1:0];
   endfunction

   function automatic logic [pcmq_pkg::PRIO_W-1:0] prio_to_port(
      input logic [PRIO_BITS-1:0] v);
      logic [PRIO_BITS+pcmq_pkg::PRIO_W-1:0] w;
      w = {{pcmq_pkg::PRIO_W{1'b0}}, v};
      return w[pcmq_pkg::PRIO_W-1:0];
   endfunction

   function automatic logic [pcmq_pkg::ID_W-1:0] idx_to_port(input logic [IDX_W-1:0] v);
      logic [IDX_W+pcmq_pkg::ID_W-1:0] w;
      w = {{pcmq_pkg::ID_W{1'b0}}, v};
      return w[pcmq_pkg::ID_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] id_to_idx(input logic [pcmq_pkg::ID_W-1:0] v);
      logic [IDX_W+pcmq_pkg::ID_W-1:0] w;
      w = {{IDX_W{1'b0}}, v};
      return w[IDX_W-1:0];
   endfunction

   // Entry memory.
   entry_type mem [DEPTH];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] mem_raddr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;

   // Control and response registers.
   state_type        state_ff, state_in;
   logic [pcmq_pkg::OP_W-1:0] op_ff, op_in;
   logic [IDX_W-1:0] id_ff, id_in;
   logic [CNT_W-1:0] next_free_ff, next_free_in;
   logic [CNT_W-1:0] scan_addr_ff, scan_addr_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   entry_type        best_ff, best_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pcmq_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [pcmq_pkg::ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic [pcmq_pkg::PAYLOAD_W-1:0]     rsp_payload_ff, rsp_payload_in;
   logic [pcmq_pkg::PRIO_W-1:0]        rsp_prio_ff, rsp_prio_in;
   logic                               rsp_live_ff, rsp_live_in;

   logic             accept;
   logic             known;
   logic             chk_last;
   logic [PRIO_BITS-1:0] prio_inc;

   assign accept   = start && (state_ff == ST_IDLE);
   assign known    = {{CNT_W{1'b0}}, req_id} < {{pcmq_pkg::ID_W{1'b0}}, next_free_ff};
   assign chk_last = {1'b0, chk_idx_ff} == CNT_W'(next_free_ff - 1'b1);
   assign prio_inc = (rd_data_ff.prio == {PRIO_BITS{1'b1}}) ? rd_data_ff.prio
                                                             : rd_data_ff.prio + 1'b1;

   // Sequencer: decode a transfer, read or scan the memory, write back, answer.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      next_free_in   = next_free_ff;
      scan_addr_in   = scan_addr_ff;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_in        = best_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_prio_in    = rsp_prio_ff;
      rsp_live_in    = rsp_live_ff;
      mem_raddr      = '0;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_op;
               id_in = id_to_idx(req_id);
               // Refusals answer at once with every other field zero.
               rsp_id_in      = '0;
               rsp_payload_in = '0;
               rsp_prio_in    = '0;
               rsp_live_in    = 1'b0;
               case (req_op)
                  pcmq_pkg::OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (next_free_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = pcmq_pkg::STAT_FULL;
                     end else begin
                        mem_we            = 1'b1;
                        mem_waddr         = next_free_ff[IDX_W-1:0];
                        mem_wdata.live    = 1'b1;
                        mem_wdata.prio    = '0;
                        mem_wdata.payload = pay_to_store(req_payload);
                        next_free_in      = next_free_ff + 1'b1;
                        rsp_status_in     = pcmq_pkg::STAT_OK;
                        rsp_id_in         = idx_to_port(next_free_ff[IDX_W-1:0]);
                        rsp_payload_in    = pay_to_port(pay_to_store(req_payload));
                        rsp_live_in       = 1'b1;
                     end
                  end
                  pcmq_pkg::OP_PROMOTE,
                  pcmq_pkg::OP_LOOKUP: begin
                     if (known) begin
                        mem_raddr = id_to_idx(req_id);
                        state_in  = ST_ENTRY;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pcmq_pkg::STAT_BAD_ID;
                     end
                  end
                  pcmq_pkg::OP_POP,
                  pcmq_pkg::OP_PEEK: begin
                     if (next_free_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pcmq_pkg::STAT_EMPTY;
                     end else begin
                        mem_raddr    = '0;
                        scan_addr_in = CNT_W'(1);
                        chk_idx_in   = '0;
                        found_in     = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pcmq_pkg::STAT_BAD_ID;
                  end
               endcase
            end
         end

         ST_ENTRY: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (op_ff == pcmq_pkg::OP_PROMOTE && !rd_data_ff.live) begin
               rsp_status_in  = pcmq_pkg::STAT_BAD_ID;
            end else begin
               rsp_status_in  = pcmq_pkg::STAT_OK;
               rsp_id_in      = idx_to_port(id_ff);
               rsp_payload_in = pay_to_port(rd_data_ff.payload);
               rsp_prio_in    = prio_to_port(rd_data_ff.prio);
               rsp_live_in    = rd_data_ff.live;
               if (op_ff == pcmq_pkg::OP_PROMOTE) begin
                  mem_we         = 1'b1;
                  mem_waddr      = id_ff;
                  mem_wdata      = rd_data_ff;
                  mem_wdata.prio = prio_inc;
                  rsp_prio_in    = prio_to_port(prio_inc);
               end
            end
         end

         ST_SCAN: begin
            // One read issued and one entry compared per cycle; ties go to the later id.
            mem_raddr    = scan_addr_ff[IDX_W-1:0];
            scan_addr_in = scan_addr_ff + 1'b1;
            chk_idx_in   = chk_idx_ff + 1'b1;
            if (rd_data_ff.live && (!found_ff || rd_data_ff.prio >= best_ff.prio)) begin
               found_in    = 1'b1;
               best_idx_in = chk_idx_ff;
               best_in     = rd_data_ff;
            end
            if (chk_last) begin
               state_in = ST_SCAN_DONE;
            end
         end

         ST_SCAN_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (!found_ff) begin
               rsp_status_in = pcmq_pkg::STAT_EMPTY;
            end else begin
               rsp_status_in  = pcmq_pkg::STAT_OK;
               rsp_id_in      = idx_to_port(best_idx_ff);
               rsp_payload_in = pay_to_port(best_ff.payload);
               rsp_prio_in    = prio_to_port(best_ff.prio);
               rsp_live_in    = (op_ff != pcmq_pkg::OP_POP);
               if (op_ff == pcmq_pkg::OP_POP) begin
                  mem_we         = 1'b1;
                  mem_waddr      = best_idx_ff;
                  mem_wdata      = best_ff;
                  mem_wdata.live = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      op_ff          <= op_in;
      id_ff          <= id_in;
      scan_addr_ff   <= scan_addr_in;
      chk_idx_ff     <= chk_idx_in;
      best_idx_ff    <= best_idx_in;
      best_ff        <= best_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_prio_ff    <= rsp_prio_in;
      rsp_live_ff    <= rsp_live_in;
   end

   // Entry memory: one write and one registered read per cycle. Every write happens in
   // the last cycle of a request, so a later read never overlaps it.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_id       = rsp_id_ff;
   assign rsp_result_payload  = rsp_payload_ff;
   assign rsp_result_priority = rsp_prio_ff;
   assign rsp_live            = rsp_live_ff;

   // A response is only ever shown after the sequencer has returned to idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> !busy)
      else $error("response strobe while a request is still in progress");

   // An add transfer answers in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == pcmq_pkg::OP_ADD) |=> rsp_valid_ff)
      else $error("add transfer produced no response");

   // The id counter never passes the store depth.
   assert property (@(posedge clock) disable iff (reset) next_free_ff <= CNT_W'(DEPTH))
      else $error("id counter beyond store depth");

   // The id counter only ever steps up by one.
   assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && next_free_ff != $past(next_free_ff))
         |-> next_free_ff == CNT_W'($past(next_free_ff) + 1'b1))
      else $error("id counter moved by other than one");

   // The scan never compares an entry that was not handed out.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ({1'b0, chk_idx_ff} < next_free_ff))
      else $error("scan ran past the last assigned id");

endmodule
